/* rtl/rounded_card_coverage_alpha_macros.svh */
// Assertion helpers for the rounded card block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ROUNDED_CARD_COVERAGE_ALPHA_MACROS_SVH
`define ROUNDED_CARD_COVERAGE_ALPHA_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rounded card check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rounded card check failed");

`endif

/* rtl/rcca_pkg.sv */
package rcca_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DIM_W    = 11;
    localparam int RADIUS_W = 10;
    localparam int BORDER_W = 8;
    localparam int COLOR_W  = 24;
    localparam int CH_W     = 8;
    localparam int COV_W    = 4;

    // Geometry in sixths of a pixel fits in this many bits.
    localparam int GEOM_W = 14;
    // Sample offsets from the corner center, and their squares.
    localparam int DX_W   = 15;
    localparam int SQ_W   = 28;
    // Blend and premultiply sums before the divide by nine.
    localparam int SUM_W  = 12;

    localparam int FRONT_STAGES = 5;
    localparam int BACK_STAGES  = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [COV_W-1:0] COV_FULL = 4'd9;
    localparam logic [COV_W-1:0] COV_NONE = 4'd0;

    localparam logic [DIM_W-1:0]    CARD_WIDTH_RST    = 11'd180;
    localparam logic [DIM_W-1:0]    CARD_HEIGHT_RST   = 11'd44;
    localparam logic [RADIUS_W-1:0] CORNER_RADIUS_RST = 10'd10;
    localparam logic [BORDER_W-1:0] BORDER_WIDTH_RST  = 8'd1;
    localparam logic [DIM_W-1:0]    ACCENT_WIDTH_RST  = 11'd4;
    localparam logic [COLOR_W-1:0]  BORDER_COLOR_RST  = 24'h3A3A40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARD_WIDTH    = 3'd0,
        CFG_CARD_HEIGHT   = 3'd1,
        CFG_CORNER_RADIUS = 3'd2,
        CFG_BORDER_WIDTH  = 3'd3,
        CFG_ACCENT_WIDTH  = 3'd4,
        CFG_BORDER_COLOR  = 3'd5
    } cfg_idx_t;

    // Color of a pixel as it travels through the front part.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            acc_ok;
    } pix_t;

    // One queue entry: color, card coverage and border weight in ninths.
    typedef struct packed {
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [COV_W-1:0] cov;
        logic [COV_W-1:0] bweight;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Load enables of the three coverage stages.
    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } cov_en_t;

    // Round-half-up divide by nine: floor((2n + 9) / 18) = floor((n + 4) / 9),
    // done by a reciprocal multiply that is exact for n below 2300.
    function automatic logic [CH_W-1:0] div9r(input logic [SUM_W-1:0] n);
        logic [SUM_W:0]   k;
        logic [24:0]      prod;
        k    = {1'b0, n} + 13'd4;
        prod = 25'(k) * 25'd7282;
        return prod[23:16];
    endfunction

endpackage

/* rtl/rcca_cov.sv */
module rcca_cov #(
    parameter int SW = 16
) (
    input  logic                           clk,
    input  rcca_pkg::cov_en_t              en,
    input  logic signed [SW-1:0]           x0,
    input  logic signed [SW-1:0]           y0,
    input  logic signed [SW-1:0]           lo,
    input  logic signed [SW-1:0]           hx,
    input  logic signed [SW-1:0]           hy,
    input  logic signed [SW-1:0]           rad,
    input  logic                           rect_ok,
    output logic [rcca_pkg::COV_W-1:0]     cov
);
    import rcca_pkg::*;

    localparam logic signed [SW-1:0] SIX = SW'(6);
    localparam int PW = 2 * DX_W;

    logic signed [SW-1:0] lox;
    logic signed [SW-1:0] hix;
    logic signed [SW-1:0] hiy;
    logic signed [SW-1:0] smp_x [3];
    logic signed [SW-1:0] smp_y [3];
    logic signed [SW-1:0] cl_x  [3];
    logic signed [SW-1:0] cl_y  [3];
    logic signed [SW-1:0] d_x   [3];
    logic signed [SW-1:0] d_y   [3];
    logic                 outside;
    logic                 corner;
    logic                 inb_x [3];
    logic                 inb_y [3];

    logic                    a_out_reg;
    logic                    a_corner_reg;
    logic                    a_inbx_reg [3];
    logic                    a_inby_reg [3];
    logic signed [DX_W-1:0]  a_dx_reg [3];
    logic signed [DX_W-1:0]  a_dy_reg [3];
    logic signed [DX_W-1:0]  a_rad_reg;

    logic signed [PW-1:0]    sq_x [3];
    logic signed [PW-1:0]    sq_y [3];
    logic signed [PW-1:0]    sq_r;

    logic                    b_out_reg;
    logic                    b_corner_reg;
    logic                    b_inbx_reg [3];
    logic                    b_inby_reg [3];
    logic [SQ_W-1:0]         b_dx2_reg [3];
    logic [SQ_W-1:0]         b_dy2_reg [3];
    logic [SQ_W-1:0]         b_rr_reg;

    logic [COV_W-1:0]        hits;
    logic [COV_W-1:0]        cov_next;
    logic [COV_W-1:0]        cov_reg;

    // Stage A: edge tests, corner box test and offsets of the nine samples.
    always_comb
    begin
        lox = lo + rad;
        hix = hx - rad;
        hiy = hy - rad;
        outside = !rect_ok || (x0 + SIX <= lo) || (y0 + SIX <= lo) ||
                  (x0 >= hx) || (y0 >= hy);
        corner  = (rad > SW'(0)) && ((x0 < lox) || (x0 + SIX > hix)) &&
                  ((y0 < lox) || (y0 + SIX > hiy));
        for (int i = 0; i < 3; i++)
        begin
            smp_x[i] = x0 + SW'(2 * i + 1);
            smp_y[i] = y0 + SW'(2 * i + 1);
            inb_x[i] = (smp_x[i] >= lo) && (smp_x[i] <= hx);
            inb_y[i] = (smp_y[i] >= lo) && (smp_y[i] <= hy);
            cl_x[i]  = (smp_x[i] < lox) ? lox : ((smp_x[i] > hix) ? hix : smp_x[i]);
            cl_y[i]  = (smp_y[i] < lox) ? lox : ((smp_y[i] > hiy) ? hiy : smp_y[i]);
            d_x[i]   = smp_x[i] - cl_x[i];
            d_y[i]   = smp_y[i] - cl_y[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_a)
        begin
            a_out_reg    <= outside;
            a_corner_reg <= corner;
            a_rad_reg    <= rad[DX_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                a_inbx_reg[i] <= inb_x[i];
                a_inby_reg[i] <= inb_y[i];
                a_dx_reg[i]   <= d_x[i][DX_W-1:0];
                a_dy_reg[i]   <= d_y[i][DX_W-1:0];
            end
        end
    end

    // Stage B: squares of the offsets and of the radius.
    always_comb
    begin
        sq_r = PW'(a_rad_reg) * PW'(a_rad_reg);
        for (int i = 0; i < 3; i++)
        begin
            sq_x[i] = PW'(a_dx_reg[i]) * PW'(a_dx_reg[i]);
            sq_y[i] = PW'(a_dy_reg[i]) * PW'(a_dy_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_b)
        begin
            b_out_reg    <= a_out_reg;
            b_corner_reg <= a_corner_reg;
            b_rr_reg     <= sq_r[SQ_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                b_inbx_reg[i] <= a_inbx_reg[i];
                b_inby_reg[i] <= a_inby_reg[i];
                b_dx2_reg[i]  <= sq_x[i][SQ_W-1:0];
                b_dy2_reg[i]  <= sq_y[i][SQ_W-1:0];
            end
        end
    end

    // Stage C counts the inside samples in a corner box; else nine or zero.
    always_comb
    begin
        hits = COV_NONE;
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (b_inbx_reg[i] && b_inby_reg[j] &&
                    (({1'b0, b_dx2_reg[i]} + {1'b0, b_dy2_reg[j]}) <= {1'b0, b_rr_reg}))
                begin
                    hits = hits + 4'd1;
                end
            end
        end
        if (b_out_reg)
        begin
            cov_next = COV_NONE;
        end
        else if (b_corner_reg)
        begin
            cov_next = hits;
        end
        else
        begin
            cov_next = COV_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld_c)
        begin
            cov_reg <= cov_next;
        end
    end

    assign cov = cov_reg;

endmodule

/* rtl/rcca_front.sv */
module rcca_front #(
    parameter int CW = 11,
    parameter int SW = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [CW-1:0]                     pixel_x,
    input  logic [CW-1:0]                     pixel_y,
    input  logic [rcca_pkg::CH_W-1:0]         pixel_blue,
    input  logic [rcca_pkg::CH_W-1:0]         pixel_green,
    input  logic [rcca_pkg::CH_W-1:0]         pixel_red,
    input  logic [rcca_pkg::DIM_W-1:0]        card_width,
    input  logic [rcca_pkg::DIM_W-1:0]        card_height,
    input  logic [rcca_pkg::RADIUS_W-1:0]     corner_radius,
    input  logic [rcca_pkg::BORDER_W-1:0]     border_width,
    input  logic [rcca_pkg::DIM_W-1:0]        accent_width,
    input  rcca_pkg::q_stat_t                 qstat,
    output logic                              push,
    output rcca_pkg::qent_t                   push_data
);
    import rcca_pkg::*;

    localparam int NS = FRONT_STAGES;
    localparam logic signed [SW-1:0] SIX   = SW'(6);
    localparam logic signed [SW-1:0] THREE = SW'(3);
    localparam logic signed [SW-1:0] ZERO  = SW'(0);

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] rdy;

    pix_t pix_reg [NS];

    logic [DIM_W-1:0]      min_dim;
    logic [BORDER_W-1:0]   bw_eff;
    logic signed [SW-1:0]  w6;
    logic signed [SW-1:0]  h6;
    logic signed [SW-1:0]  rq6;
    logic signed [SW-1:0]  half6;
    logic signed [SW-1:0]  bw6;

    logic signed [SW-1:0]  s0_x0_reg;
    logic signed [SW-1:0]  s0_y0_reg;
    logic signed [SW-1:0]  s0_w6_reg;
    logic signed [SW-1:0]  s0_h6_reg;
    logic signed [SW-1:0]  s0_r6_reg;
    logic signed [SW-1:0]  s0_bw6_reg;

    logic signed [SW-1:0]  s1_x0_reg;
    logic signed [SW-1:0]  s1_y0_reg;
    logic signed [SW-1:0]  s1_ohx_reg;
    logic signed [SW-1:0]  s1_ohy_reg;
    logic signed [SW-1:0]  s1_orad_reg;
    logic                  s1_ook_reg;
    logic signed [SW-1:0]  s1_ilo_reg;
    logic signed [SW-1:0]  s1_ihx_reg;
    logic signed [SW-1:0]  s1_ihy_reg;
    logic signed [SW-1:0]  s1_irad_reg;
    logic                  s1_iok_reg;

    cov_en_t               cen;
    logic [COV_W-1:0]      cov_outer;
    logic [COV_W-1:0]      cov_inner;

    // Each stage moves on when it is empty or the stage after it moves.
    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || !qstat.full;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall = !rdy[0];

    // Card geometry in sixths of a pixel, with the radius clamped.
    always_comb
    begin
        min_dim = (card_width < card_height) ? card_width : card_height;
        bw_eff  = (border_width == '0) ? 8'd1 : border_width;
        w6      = $signed(SW'(card_width)) * SIX;
        h6      = $signed(SW'(card_height)) * SIX;
        rq6     = $signed(SW'(corner_radius)) * SIX;
        half6   = $signed(SW'(min_dim)) * THREE;
        bw6     = $signed(SW'(bw_eff)) * SIX;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pix_reg[0].blue   <= pixel_blue;
            pix_reg[0].green  <= pixel_green;
            pix_reg[0].red    <= pixel_red;
            pix_reg[0].acc_ok <= SW'(pixel_x) >= SW'(accent_width);
            s0_x0_reg  <= $signed(SW'(pixel_x)) * SIX;
            s0_y0_reg  <= $signed(SW'(pixel_y)) * SIX;
            s0_w6_reg  <= w6;
            s0_h6_reg  <= h6;
            s0_r6_reg  <= (rq6 < half6) ? rq6 : half6;
            s0_bw6_reg <= bw6;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[k])
            begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
    end

    // Outer card rectangle and the inner rectangle inset by the border.
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s1_x0_reg   <= s0_x0_reg;
            s1_y0_reg   <= s0_y0_reg;
            s1_ohx_reg  <= s0_w6_reg;
            s1_ohy_reg  <= s0_h6_reg;
            s1_orad_reg <= s0_r6_reg;
            s1_ook_reg  <= (s0_w6_reg > ZERO) && (s0_h6_reg > ZERO);
            s1_ilo_reg  <= s0_bw6_reg;
            s1_ihx_reg  <= s0_w6_reg - s0_bw6_reg;
            s1_ihy_reg  <= s0_h6_reg - s0_bw6_reg;
            s1_irad_reg <= (s0_r6_reg > s0_bw6_reg) ? s0_r6_reg - s0_bw6_reg : ZERO;
            s1_iok_reg  <= (s0_w6_reg > s0_bw6_reg + s0_bw6_reg) &&
                           (s0_h6_reg > s0_bw6_reg + s0_bw6_reg);
        end
    end

    always_comb
    begin
        cen.ld_a = rdy[2];
        cen.ld_b = rdy[3];
        cen.ld_c = rdy[4];
    end

    rcca_cov #(
        .SW      (SW)
    ) u_cov_outer (
        .clk     (clk),
        .en      (cen),
        .x0      (s1_x0_reg),
        .y0      (s1_y0_reg),
        .lo      (ZERO),
        .hx      (s1_ohx_reg),
        .hy      (s1_ohy_reg),
        .rad     (s1_orad_reg),
        .rect_ok (s1_ook_reg),
        .cov     (cov_outer)
    );

    rcca_cov #(
        .SW      (SW)
    ) u_cov_inner (
        .clk     (clk),
        .en      (cen),
        .x0      (s1_x0_reg),
        .y0      (s1_y0_reg),
        .lo      (s1_ilo_reg),
        .hx      (s1_ihx_reg),
        .hy      (s1_ihy_reg),
        .rad     (s1_irad_reg),
        .rect_ok (s1_iok_reg),
        .cov     (cov_inner)
    );

    // Border weight: the part between the outlines; zero left of accent_width.
    always_comb
    begin
        push              = vld_reg[NS-1] && !qstat.full;
        push_data.blue    = pix_reg[NS-1].blue;
        push_data.green   = pix_reg[NS-1].green;
        push_data.red     = pix_reg[NS-1].red;
        push_data.cov     = cov_outer;
        push_data.bweight = (pix_reg[NS-1].acc_ok && (cov_outer > cov_inner)) ?
                            cov_outer - cov_inner : COV_NONE;
    end

endmodule

/* rtl/rcca_queue.sv */
module rcca_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rcca_pkg::qent_t   push_data,
    input  logic              pop,
    output rcca_pkg::qent_t   pop_data,
    output rcca_pkg::q_stat_t qstat
);
    import rcca_pkg::*;

    qent_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_CNT_W-1:0]  cnt_reg;
    logic [Q_CNT_W-1:0]  cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = mem_reg[rd_ptr_reg];
    assign qstat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

endmodule

/* rtl/rcca_back.sv */
module rcca_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rcca_pkg::q_stat_t              qstat,
    output logic                           pop,
    input  rcca_pkg::qent_t                pop_data,
    input  logic [rcca_pkg::COLOR_W-1:0]   border_color,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rcca_pkg::CH_W-1:0]      out_blue,
    output logic [rcca_pkg::CH_W-1:0]      out_green,
    output logic [rcca_pkg::CH_W-1:0]      out_red,
    output logic [rcca_pkg::CH_W-1:0]      out_alpha
);
    import rcca_pkg::*;

    localparam int NS = BACK_STAGES;
    localparam logic [SUM_W-1:0] NINE      = SUM_W'(9);
    localparam logic [SUM_W-1:0] ALPHA_MAX = SUM_W'(255);

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] rdy;

    logic [CH_W-1:0]  ch_in [3];
    logic [CH_W-1:0]  bc    [3];
    logic [SUM_W-1:0] blend [3];

    logic [SUM_W-1:0] b0_sum_reg [3];
    logic [COV_W-1:0] b0_cov_reg;
    logic [CH_W-1:0]  b1_c_reg [3];
    logic [COV_W-1:0] b1_cov_reg;
    logic [CH_W-1:0]  b2_c_reg [3];
    logic [SUM_W-1:0] b2_p_reg [3];
    logic [COV_W-1:0] b2_cov_reg;
    logic [CH_W-1:0]  out_ch_next [3];
    logic [CH_W-1:0]  out_ch_reg  [3];
    logic [CH_W-1:0]  alpha_next;
    logic [CH_W-1:0]  alpha_reg;

    always_comb
    begin
        rdy[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = !qstat.empty;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pop = rdy[0] && !qstat.empty;

    // Border blend; a zero weight leaves the channel as it is.
    always_comb
    begin
        ch_in[0] = pop_data.blue;
        ch_in[1] = pop_data.green;
        ch_in[2] = pop_data.red;
        bc[0]    = border_color[7:0];
        bc[1]    = border_color[15:8];
        bc[2]    = border_color[23:16];
        for (int i = 0; i < 3; i++)
        begin
            blend[i] = SUM_W'(ch_in[i]) * (NINE - SUM_W'(pop_data.bweight)) +
                       SUM_W'(bc[i]) * SUM_W'(pop_data.bweight);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            b0_sum_reg <= blend;
            b0_cov_reg <= pop_data.cov;
        end
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                b1_c_reg[i] <= div9r(b0_sum_reg[i]);
            end
            b1_cov_reg <= b0_cov_reg;
        end
        if (rdy[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                b2_c_reg[i] <= b1_c_reg[i];
                b2_p_reg[i] <= SUM_W'(b1_c_reg[i]) * SUM_W'(b1_cov_reg);
            end
            b2_cov_reg <= b1_cov_reg;
        end
        if (rdy[3])
        begin
            out_ch_reg <= out_ch_next;
            alpha_reg  <= alpha_next;
        end
    end

    // Premultiply by coverage; outside pixels go to zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b2_cov_reg == COV_NONE)
            begin
                out_ch_next[i] = '0;
            end
            else if (b2_cov_reg >= COV_FULL)
            begin
                out_ch_next[i] = b2_c_reg[i];
            end
            else
            begin
                out_ch_next[i] = div9r(b2_p_reg[i]);
            end
        end
        if (b2_cov_reg == COV_NONE)
        begin
            alpha_next = '0;
        end
        else if (b2_cov_reg >= COV_FULL)
        begin
            alpha_next = ALPHA_MAX[CH_W-1:0];
        end
        else
        begin
            alpha_next = div9r(SUM_W'(b2_cov_reg) * ALPHA_MAX);
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_blue  = out_ch_reg[0];
    assign out_green = out_ch_reg[1];
    assign out_red   = out_ch_reg[2];
    assign out_alpha = alpha_reg;

endmodule

/* rtl/rounded_card_coverage_alpha.sv */
// Rounded card mask: each input word is one pixel of a card (its column, row
// and the color already drawn there), and each output word is that pixel as
// premultiplied BGRA. The card is a rounded rectangle whose corner radius is
// clamped to half the smaller side. Pixels on straight parts are either fully
// inside or fully outside; pixels in the four corner boxes are covered by a
// 3x3 grid of sample points, giving coverage in ninths. An inner border of
// border_width pixels in border_color is blended in by the share of the pixel
// that lies between the card outline and the inset outline, except in columns
// left of accent_width. All geometry runs in sixths of a pixel, so sample
// points are exact integers, and every division by nine rounds half up.
// The block takes one pixel per clock for as long as the output is not
// stalled. A word passes through ten registers, the first of them loaded at
// the edge that accepts it: five front stages (input register, rectangle
// setup, sample offsets, the squarers of the sample distances, and the sample
// count), a two-entry queue, and four back stages for the border blend and
// the premultiply, the last of which is the output register. The queue lets
// the front keep accepting pixels while a result waits at the output, until
// the queue is full.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data and take effect for the next accepted pixel; writes to an unknown
// index are dropped. Write them only while no pixel is in flight.

`include "rounded_card_coverage_alpha_macros.svh"

module rounded_card_coverage_alpha #(
    parameter int COORD_WIDTH = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rcca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcca_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [COORD_WIDTH-1:0]           pixel_x,
    input  logic [COORD_WIDTH-1:0]           pixel_y,
    input  logic [rcca_pkg::CH_W-1:0]        pixel_blue,
    input  logic [rcca_pkg::CH_W-1:0]        pixel_green,
    input  logic [rcca_pkg::CH_W-1:0]        pixel_red,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rcca_pkg::CH_W-1:0]        out_blue,
    output logic [rcca_pkg::CH_W-1:0]        out_green,
    output logic [rcca_pkg::CH_W-1:0]        out_red,
    output logic [rcca_pkg::CH_W-1:0]        out_alpha
);
    import rcca_pkg::*;

    // Width of signed coordinates in sixths: wide enough for the pixel
    // position times six and for the card geometry, with room for sums.
    localparam int SW = ((COORD_WIDTH + 3 > GEOM_W) ? COORD_WIDTH + 3 : GEOM_W) + 2;

    logic [DIM_W-1:0]    card_width_reg;
    logic [DIM_W-1:0]    card_height_reg;
    logic [RADIUS_W-1:0] corner_radius_reg;
    logic [BORDER_W-1:0] border_width_reg;
    logic [DIM_W-1:0]    accent_width_reg;
    logic [COLOR_W-1:0]  border_color_reg;

    logic      q_push;
    qent_t     q_push_data;
    logic      q_pop;
    qent_t     q_pop_data;
    q_stat_t   q_stat;
    logic      premult_ok;

    // Configuration registers. Each takes the low bits of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_width_reg    <= CARD_WIDTH_RST;
            card_height_reg   <= CARD_HEIGHT_RST;
            corner_radius_reg <= CORNER_RADIUS_RST;
            border_width_reg  <= BORDER_WIDTH_RST;
            accent_width_reg  <= ACCENT_WIDTH_RST;
            border_color_reg  <= BORDER_COLOR_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CARD_WIDTH:    card_width_reg    <= cfg_data[DIM_W-1:0];
                CFG_CARD_HEIGHT:   card_height_reg   <= cfg_data[DIM_W-1:0];
                CFG_CORNER_RADIUS: corner_radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_BORDER_WIDTH:  border_width_reg  <= cfg_data[BORDER_W-1:0];
                CFG_ACCENT_WIDTH:  accent_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_BORDER_COLOR:  border_color_reg  <= cfg_data[COLOR_W-1:0];
                default:           ;
            endcase
        end
    end

    // The front part finds the card and inner coverage of each pixel and
    // the border weight, then hands the word to the queue.
    rcca_front #(
        .CW            (COORD_WIDTH),
        .SW            (SW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_blue    (pixel_blue),
        .pixel_green   (pixel_green),
        .pixel_red     (pixel_red),
        .card_width    (card_width_reg),
        .card_height   (card_height_reg),
        .corner_radius (corner_radius_reg),
        .border_width  (border_width_reg),
        .accent_width  (accent_width_reg),
        .qstat         (q_stat),
        .push          (q_push),
        .push_data     (q_push_data)
    );

    rcca_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .qstat     (q_stat)
    );

    // The back part blends the border color and premultiplies by coverage.
    rcca_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (q_stat),
        .pop          (q_pop),
        .pop_data     (q_pop_data),
        .border_color (border_color_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_blue     (out_blue),
        .out_green    (out_green),
        .out_red      (out_red),
        .out_alpha    (out_alpha)
    );

    assign premult_ok = (out_blue <= out_alpha) && (out_green <= out_alpha) &&
                        (out_red <= out_alpha);

    // A premultiplied channel never exceeds its alpha.
    `RCCA_ASSERT_NOW(a_premult_bound, out_valid, premult_ok)
    // A word pushed into the queue is there on the next cycle.
    `RCCA_ASSERT_NEXT(a_push_lands, q_push, !q_stat.empty)
    // The queue cannot be reported both full and empty.
    `RCCA_ASSERT_NOW(a_queue_flags, q_stat.full, !q_stat.empty)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the rounded card mask. Pixel words are queued by the
// stimulus process, presented by a clocked driver and checked by a clocked
// monitor against a prediction made when each word is accepted.
module tb_top;

    import rcca_pkg::*;

    localparam int COORD_W = 11;
    localparam int PHASES = 12;
    localparam int PIXELS_PER_PHASE = 75;
    // Time left for the pipeline to drain before touching the registers or
    // ending the run.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    // Register indexes that map to nothing; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    // One input word: pixel position and the color drawn there.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CH_W-1:0]    blue;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    red;
    } pixel_word_t;

    // One output word: premultiplied BGRA.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] alpha;
    } card_pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_W-1:0]    pixel_x = '0;
    logic [COORD_W-1:0]    pixel_y = '0;
    logic [CH_W-1:0]       pixel_blue = '0;
    logic [CH_W-1:0]       pixel_green = '0;
    logic [CH_W-1:0]       pixel_red = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CH_W-1:0]       out_blue;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_red;
    logic [CH_W-1:0]       out_alpha;

    // Our own copy of the card registers, updated as each write is issued.
    // Writes only happen while no pixel is in flight, so that is safe.
    logic [DIM_W-1:0]    set_width;
    logic [DIM_W-1:0]    set_height;
    logic [RADIUS_W-1:0] set_radius;
    logic [BORDER_W-1:0] set_border;
    logic [DIM_W-1:0]    set_accent;
    logic [COLOR_W-1:0]  set_color;

    pixel_word_t pending_words[$];
    card_pixel_t expected_pixels[$];
    pixel_word_t driven_word;
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_idle_pct = 0;

    rounded_card_coverage_alpha #(
        .COORD_WIDTH (COORD_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_blue  (pixel_blue),
        .pixel_green (pixel_green),
        .pixel_red   (pixel_red),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_blue    (out_blue),
        .out_green   (out_green),
        .out_red     (out_red),
        .out_alpha   (out_alpha)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // Divide by nine, rounding half up.
    function automatic int unsigned round_ninth(input int unsigned n);
        return (2 * n + 9) / 18;
    endfunction

    // Is the point (x, y) inside the rounded rectangle [l, l+w] x [t, t+h]
    // with corner radius r? Everything is in sixths of a pixel.
    function automatic bit point_in_card(input longint x, input longint y,
                                         input longint l, input longint t,
                                         input longint w, input longint h,
                                         input longint r);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        if (x < l || y < t || x > l + w || y > t + h)
            return 1'b0;
        if (r <= 0)
            return 1'b1;
        // Distance from the nearest point of the rectangle shrunk by r.
        cx = lmin(lmax(x, l + r), l + w - r);
        cy = lmin(lmax(y, t + r), t + h - r);
        dx = x - cx;
        dy = y - cy;
        return dx * dx + dy * dy <= r * r;
    endfunction

    // Coverage of pixel (px, py) in ninths. Pixels inside a corner box use a
    // 3x3 grid of sample points; elsewhere the overlap area is exact.
    function automatic int unsigned pixel_coverage(input longint px, input longint py,
                                                   input longint l, input longint t,
                                                   input longint w, input longint h,
                                                   input longint r);
        longint x0;
        longint y0;
        longint ov_w;
        longint ov_h;
        bit near_x;
        bit near_y;
        int unsigned hits;
        int sx;
        int sy;
        if (w <= 0 || h <= 0)
            return 0;
        x0 = px * 6;
        y0 = py * 6;
        if (x0 + 6 <= l || y0 + 6 <= t || x0 >= l + w || y0 >= t + h)
            return 0;
        if (r > 0)
        begin
            near_x = (x0 < l + r) || (x0 + 6 > l + w - r);
            near_y = (y0 < t + r) || (y0 + 6 > t + h - r);
            if (near_x && near_y)
            begin
                hits = 0;
                for (sy = 0; sy < 3; sy++)
                    for (sx = 0; sx < 3; sx++)
                        if (point_in_card(x0 + 2 * sx + 1, y0 + 2 * sy + 1, l, t, w, h, r))
                            hits++;
                return hits;
            end
        end
        if (x0 >= l && x0 + 6 <= l + w && y0 >= t && y0 + 6 <= t + h)
            return 9;
        ov_w = lmin(x0 + 6, l + w) - lmax(x0, l);
        ov_h = lmin(y0 + 6, t + h) - lmax(y0, t);
        if (ov_w <= 0 || ov_h <= 0)
            return 0;
        return int'((ov_w * ov_h) / 4);
    endfunction

    // What the block must return for one pixel under the current registers.
    function automatic card_pixel_t predict_card_pixel(input pixel_word_t word);
        longint px;
        longint py;
        longint w6;
        longint h6;
        longint r6;
        longint bw6;
        longint ir6;
        int unsigned cov;
        int unsigned inner;
        int unsigned share;
        int unsigned chan[3];
        int unsigned bcol[3];
        int i;
        card_pixel_t res;
        px = longint'(word.x);
        py = longint'(word.y);
        chan[0] = word.blue;
        chan[1] = word.green;
        chan[2] = word.red;
        bcol[0] = set_color[7:0];
        bcol[1] = set_color[15:8];
        bcol[2] = set_color[23:16];
        w6 = longint'(set_width) * 6;
        h6 = longint'(set_height) * 6;
        r6 = lmin(longint'(set_radius) * 6, lmin(w6, h6) / 2);
        // A border width of zero behaves as one pixel.
        bw6 = (set_border == '0) ? 6 : longint'(set_border) * 6;
        res = '0;
        cov = pixel_coverage(px, py, 0, 0, w6, h6, r6);
        if (cov == 0)
            return res;
        // The border is the part of the card outside the inset outline; it is
        // left out over the accent bar.
        if (px >= longint'(set_accent))
        begin
            ir6 = lmax(r6 - bw6, 0);
            inner = pixel_coverage(px, py, bw6, bw6, w6 - 2 * bw6, h6 - 2 * bw6, ir6);
            if (cov > inner)
            begin
                share = cov - inner;
                for (i = 0; i < 3; i++)
                    chan[i] = round_ninth(chan[i] * (9 - share) + bcol[i] * share);
            end
        end
        if (cov >= COV_FULL)
        begin
            res.alpha = 8'd255;
        end
        else
        begin
            for (i = 0; i < 3; i++)
                chan[i] = round_ninth(chan[i] * cov);
            res.alpha = 8'(round_ninth(255 * cov));
        end
        res.blue = 8'(chan[0]);
        res.green = 8'(chan[1]);
        res.red = 8'(chan[2]);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Issue one register write and mirror it in our copy of the registers.
    // The write enable stays high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        logic [CFG_DATA_W-1:0] data;
        data = value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_CARD_WIDTH:    set_width = data[DIM_W-1:0];
            CFG_CARD_HEIGHT:   set_height = data[DIM_W-1:0];
            CFG_CORNER_RADIUS: set_radius = data[RADIUS_W-1:0];
            CFG_BORDER_WIDTH:  set_border = data[BORDER_W-1:0];
            CFG_ACCENT_WIDTH:  set_accent = data[DIM_W-1:0];
            CFG_BORDER_COLOR:  set_color = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // Program the whole card. With dirty set, the unused upper bits of each
    // write carry random junk that the block must ignore. Every setup also
    // writes one unmapped index, which must have no effect.
    task automatic setup_card(input int unsigned w, input int unsigned h,
                              input int unsigned r, input int unsigned bw,
                              input int unsigned acc, input int unsigned color,
                              input bit dirty);
        int unsigned junk;
        junk = dirty ? $urandom : 0;
        write_register(CFG_CARD_WIDTH, (junk << DIM_W) | w);
        write_register(CFG_CARD_HEIGHT, (junk << DIM_W) | h);
        write_register(CFG_CORNER_RADIUS, (junk << RADIUS_W) | r);
        write_register(CFG_BORDER_WIDTH, (junk << BORDER_W) | bw);
        write_register(CFG_ACCENT_WIDTH, (junk << DIM_W) | acc);
        write_register(CFG_BORDER_COLOR, color);
        write_register($urandom_range(0, 1) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B, $urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_pixel(input int unsigned x, input int unsigned y,
                               input int unsigned b, input int unsigned g,
                               input int unsigned r);
        pixel_word_t word;
        word.x = x[COORD_W-1:0];
        word.y = y[COORD_W-1:0];
        word.blue = b[CH_W-1:0];
        word.green = g[CH_W-1:0];
        word.red = r[CH_W-1:0];
        pending_words.push_back(word);
        queued_count++;
    endtask

    // Pick a coordinate along one axis of a card of the given extent. Most
    // picks land within reach of either edge, where the corners and the border
    // live; some fall anywhere on the card and a few anywhere at all.
    function automatic int unsigned pick_coord(input int extent, input int reach);
        int v;
        int off;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        off = $urandom_range(0, reach);
        if (sel < 4)
            v = off;
        else if (sel < 8)
            v = extent + 1 - off;
        else if (sel < 9)
            v = $urandom_range(0, extent + 1);
        else
            v = $urandom_range(0, (1 << COORD_W) - 1);
        if (v < 0)
            v = 0;
        if (v > (1 << COORD_W) - 1)
            v = (1 << COORD_W) - 1;
        return v;
    endfunction

    // Driver: presents queued pixel words. A stalled word is held unchanged;
    // otherwise the next word is presented unless the sender chooses to idle.
    // The expected result is computed at the edge the word is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_pixels.push_back(predict_card_pixel(driven_word));
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    driven_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    pixel_x <= driven_word.x;
                    pixel_y <= driven_word.y;
                    pixel_blue <= driven_word.blue;
                    pixel_green <= driven_word.green;
                    pixel_red <= driven_word.red;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted output word is compared field by field with the
    // oldest prediction. The receiver stalls at random, independent of valid.
    always @(posedge clk or negedge rst_n)
    begin
        card_pixel_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("output word arrived with no pixel outstanding");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_blue !== want.blue)
                        report_mismatch($sformatf("word %0d blue got %0d want %0d",
                                                  checked_count, out_blue, want.blue));
                    if (out_green !== want.green)
                        report_mismatch($sformatf("word %0d green got %0d want %0d",
                                                  checked_count, out_green, want.green));
                    if (out_red !== want.red)
                        report_mismatch($sformatf("word %0d red got %0d want %0d",
                                                  checked_count, out_red, want.red));
                    if (out_alpha !== want.alpha)
                        report_mismatch($sformatf("word %0d alpha got %0d want %0d",
                                                  checked_count, out_alpha, want.alpha));
                end
                checked_count++;
            end
            out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Watchdog: a hung handshake or a lost output word ends up here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rounded_card_coverage_alpha verification failed");
            $finish;
        end
    end

    // Stimulus: reset once, then a series of phases. Each phase after the first
    // programs the card while the block is idle; every phase queues its pixels,
    // waits until every prediction has been matched, and lets the pipeline settle.
    initial
    begin
        int phase;
        int reach_x;
        int reach_y;
        int unsigned w;
        int unsigned h;
        int unsigned acc;
        set_width = CARD_WIDTH_RST;
        set_height = CARD_HEIGHT_RST;
        set_radius = CORNER_RADIUS_RST;
        set_border = BORDER_WIDTH_RST;
        set_accent = ACCENT_WIDTH_RST;
        set_color = BORDER_COLOR_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Sender idles lightly while the receiver stalls a lot, then the
            // other way round, then both run flat out.
            if (phase < 4)
            begin
                sender_idle_pct = 10;
                receiver_idle_pct = 57;
            end
            else if (phase < 8)
            begin
                sender_idle_pct = 57;
                receiver_idle_pct = 10;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end

            case (phase)
                0:
                begin
                    // Reset values: a 180x44 card, radius 10, one pixel border,
                    // four column accent bar. Directed pixels first.
                    queue_pixel(0, 0, 255, 255, 255);         // corner, outside the arc
                    queue_pixel(2047, 2047, 255, 255, 255);   // far beyond the card
                    queue_pixel(0, 2047, 0, 255, 0);
                    queue_pixel(2047, 0, 255, 0, 255);
                    queue_pixel(180, 10, 200, 100, 50);       // just right of the card
                    queue_pixel(10, 44, 200, 100, 50);        // just below the card
                    queue_pixel(90, 22, 255, 255, 255);       // plain interior
                    queue_pixel(90, 22, 0, 0, 0);
                    queue_pixel(90, 0, 255, 0, 128);          // top border
                    queue_pixel(179, 22, 17, 34, 51);         // right border
                    queue_pixel(90, 43, 255, 255, 255);       // bottom border
                    queue_pixel(0, 22, 255, 128, 0);          // accent bar, no border
                    queue_pixel(3, 0, 99, 199, 255);          // last accent column
                    queue_pixel(4, 0, 99, 199, 255);          // first bordered column
                    queue_pixel(1, 1, 255, 255, 255);         // corner pixel, also outside the arc
                    queue_pixel(2, 1, 0, 0, 0);
                    queue_pixel(10, 1, 80, 160, 240);         // below the border where the arc ends
                    queue_pixel(175, 40, 255, 255, 255);      // bottom right corner
                    queue_pixel(179, 43, 128, 128, 128);
                end
                1: setup_card(1, 1, 0, 1, 0, 24'hFFFFFF, 1'b0);
                2: setup_card(2047, 2047, 1023, 255, 2047, 24'h000000, 1'b0);
                3: setup_card(0, 20, 4, 2, 0, 24'h123456, 1'b0);      // zero width
                4: setup_card(30, 20, 5, 0, 0, 24'hA5C3E1, 1'b0);     // zero border
                5: setup_card(8, 6, 3, 10, 0, 24'hFF00FF, 1'b0);      // border swallows card
                6: setup_card(25, 0, 3, 1, 2, 24'h00FF00, 1'b1);      // zero height
                default:
                begin
                    w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2047)
                                                    : $urandom_range(1, 64);
                    h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2047)
                                                    : $urandom_range(1, 64);
                    acc = ($urandom_range(0, 5) == 0) ? 2047 : $urandom_range(0, w + 2);
                    setup_card(w, h,
                               ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 24),
                               ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 8),
                               acc, $urandom & 24'hFFFFFF, 1'b1);
                end
            endcase

            // Random pixels clustered near the edges, where corners and the
            // border decide the result.
            reach_x = int'(set_radius) + int'(set_border) + 2;
            reach_y = reach_x;
            if (reach_x > int'(set_width) + 2)
                reach_x = int'(set_width) + 2;
            if (reach_y > int'(set_height) + 2)
                reach_y = int'(set_height) + 2;
            repeat (PIXELS_PER_PHASE)
                queue_pixel(pick_coord(set_width, reach_x), pick_coord(set_height, reach_y),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));

            while (accepted_count != queued_count || expected_pixels.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        if (error_count == 0)
            $display("rounded_card_coverage_alpha verification clean");
        else
            $display("rounded_card_coverage_alpha verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/rcca_pkg.sv
rtl/rcca_cov.sv
rtl/rcca_front.sv
rtl/rcca_queue.sv
rtl/rcca_back.sv
rtl/rounded_card_coverage_alpha.sv
tb/sv/tb_top.sv
